>>> rtl/ffba_pkg.sv
// Package for the first-fit block allocator: widths, codes and field types.
// Used by every module of the allocator; depends on nothing.
`default_nettype none
package ffba_pkg;
  localparam int MaxBlocks = 64;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = 11;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTALLOC = 2'd3;

  localparam logic [1:0] CFG_ALIGN = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_END   = 2'd2;

  typedef struct packed {
    logic        start;
    logic [31:0] off;
    logic [8:0]  align;
  } pad_req_t;

  typedef struct packed {
    logic        done;
    logic [8:0]  pad;
  } pad_rsp_t;
endpackage
`default_nettype wire

>>> rtl/ffba_pad_unit.sv
// Shared padding unit: offset mod alignment by restoring division, one bit a cycle.
// Depends on ffba_pkg. Gives the bytes needed to round an offset up to alignment.
`default_nettype none
module ffba_pad_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ffba_pkg::pad_req_t req,
  output ffba_pkg::pad_rsp_t     rsp
);
  logic [31:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [8:0]  a_r, a_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [9:0]  sh;
  logic [9:0]  diff;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    a_nxt = a_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    sh = {rem_r[8:0], q_r[31]};
    diff = sh - {1'b0, a_r};
    rsp.done = 1'b0;
    rsp.pad = '0;
    if (req.start) begin
      q_nxt = req.off;
      rem_nxt = '0;
      a_nxt = (req.align == 9'd0) ? 9'd1 : req.align;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        rsp.done = 1'b1;
        rsp.pad = (rem_r == 10'd0) ? 9'd0 : 9'(({1'b0, a_r}) - rem_r);
      end else begin
        q_nxt = {q_r[30:0], 1'b0};
        rem_nxt = (sh >= {1'b0, a_r}) ? diff : sh;
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    a_r <= a_nxt;
  end
endmodule
`default_nettype wire

>>> rtl/first_fit_block_allocator_core.sv
// First-fit block allocator top level: sequencer, block table and counters.
// Depends on ffba_pkg and ffba_pad_unit.
// Usage:
//   Input words (in_command, in_request_size, in_block_offset) use valid/ready.
//   One result word (status, offset, live cells, allocated bytes) per input word.
//   The block takes one word at a time; in_ready is low while a word is in work
//   or its result waits in the output register.
//   Init waits for one pad computation before out_valid. Allocate reads the
//   table one entry at a time through the read and evaluate states, and each
//   free entry adds a pad computation. Free reads the table the same way. With
//   an empty table or the unused command the result comes in the cycle after
//   accept. The next word is taken at the earliest in the cycle after the
//   result word is taken. The table memory read port sets the scan rate, the
//   shared bit-serial divider sets the pad cost.
//   Reset clears the counters and empties the table; registers return to
//   alignment 4, heap start 64, heap end 1048576. Write cfg_ only while idle.
//   When the receiver stalls the result holds in out_ and no new word is taken.
`default_nettype none
module first_fit_block_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_request_size,
  input  wire logic [31:0] in_block_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_result_offset,
  output logic [10:0]      out_live_cells,
  output logic [31:0]      out_allocated_bytes,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int IW = ffba_pkg::IdxW;
  localparam int CW = ffba_pkg::CntW;

  logic [8:0]  align_r;
  logic [15:0] hstart_r;
  logic [31:0] hend_r;

  logic [31:0] moff [ffba_pkg::MaxBlocks];
  logic [31:0] msize [ffba_pkg::MaxBlocks];
  logic        mfree [ffba_pkg::MaxBlocks];
  logic [31:0] rd_off_r, rd_size_r;
  logic        rd_free_r;

  logic [2:0]    st_r;
  logic [1:0]    cmd_r;
  logic [31:0]   req_r, boff_r;
  logic [CW-1:0] used_r;
  logic [CW-1:0] cells_r;
  logic [31:0]   bytes_r;
  logic [CW-1:0] idx_r;
  logic          ov_r;
  logic [1:0]    ost_r;
  logic [31:0]   ores_r;

  ffba_pkg::pad_req_t preq;
  ffba_pkg::pad_rsp_t prsp;

  ffba_pad_unit u_pad (.clk(clk), .rst_n(rst_n), .req(preq), .rsp(prsp));

  logic [IW-1:0] ridx;
  logic [IW-1:0] widx;
  logic [31:0]   woff, wsize;
  logic          wfree, we;
  logic          we2;
  logic [IW-1:0] widx2;
  logic [31:0]   woff2, wsize2;

  logic [31:0] avail, span, isize;
  logic        fits, exact;

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_result_offset = ores_r;
  assign out_live_cells = cells_r;
  assign out_allocated_bytes = bytes_r;

  assign ridx = idx_r[IW-1:0];
  assign span = (hend_r >= {16'd0, hstart_r}) ? hend_r - {16'd0, hstart_r} : 32'd0;
  assign isize = (span >= {23'd0, prsp.pad}) ? span - {23'd0, prsp.pad} : 32'd0;
  assign avail = rd_size_r - {23'd0, prsp.pad};
  assign fits = (rd_size_r >= {23'd0, prsp.pad}) && (avail >= req_r);
  assign exact = (avail == req_r);

  always_comb begin
    preq.start = 1'b0;
    preq.off = rd_off_r;
    preq.align = align_r;
    if (st_r == S_IDLE && in_valid && in_command == ffba_pkg::CMD_INIT) begin
      preq.start = 1'b1;
      preq.off = {16'd0, hstart_r};
    end else if (st_r == S_EVAL && cmd_r == ffba_pkg::CMD_ALLOC && rd_free_r) begin
      preq.start = 1'b1;
    end
  end

  always_comb begin
    we = 1'b0;
    widx = ridx;
    woff = rd_off_r + {23'd0, prsp.pad};
    wsize = avail;
    wfree = 1'b0;
    we2 = 1'b0;
    widx2 = used_r[IW-1:0];
    woff2 = rd_off_r + {23'd0, prsp.pad} + req_r;
    wsize2 = avail - req_r;
    if (st_r == S_INIT && prsp.done) begin
      we = 1'b1;
      widx = '0;
      woff = {16'd0, hstart_r} + {23'd0, prsp.pad};
      wsize = isize;
      wfree = 1'b1;
    end else if (st_r == S_PAD && prsp.done && fits &&
                 (exact || used_r < CW'(ffba_pkg::MaxBlocks))) begin
      we = 1'b1;
      if (!exact) begin
        wsize = req_r;
        we2 = 1'b1;
      end
    end else if (st_r == S_EVAL && cmd_r == ffba_pkg::CMD_FREE && !rd_free_r &&
                 rd_off_r == boff_r) begin
      we = 1'b1;
      woff = rd_off_r;
      wsize = rd_size_r;
      wfree = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_off_r <= moff[ridx];
    rd_size_r <= msize[ridx];
    rd_free_r <= mfree[ridx];
    if (we) begin
      moff[widx] <= woff;
      msize[widx] <= wsize;
      mfree[widx] <= wfree;
    end
    if (we2) begin
      moff[widx2] <= woff2;
      msize[widx2] <= wsize2;
      mfree[widx2] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= 9'd4;
      hstart_r <= 16'd64;
      hend_r <= 32'd1048576;
      st_r <= S_IDLE;
      used_r <= '0;
      cells_r <= '0;
      bytes_r <= '0;
      ov_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ffba_pkg::CFG_ALIGN: align_r <= cfg_wdata[8:0];
          ffba_pkg::CFG_START: hstart_r <= cfg_wdata[15:0];
          ffba_pkg::CFG_END:   hend_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command;
            req_r <= in_request_size;
            boff_r <= in_block_offset;
            idx_r <= '0;
            ost_r <= ffba_pkg::ST_OK;
            ores_r <= '0;
            case (in_command)
              ffba_pkg::CMD_INIT: st_r <= S_INIT;
              ffba_pkg::CMD_ALLOC, ffba_pkg::CMD_FREE: begin
                if (used_r == '0) begin
                  ost_r <= (in_command == ffba_pkg::CMD_ALLOC) ?
                           ffba_pkg::ST_NOFIT : ffba_pkg::ST_NOTALLOC;
                  st_r <= S_OUT;
                  ov_r <= 1'b1;
                end else begin
                  st_r <= S_READ;
                end
              end
              default: begin
                st_r <= S_OUT;
                ov_r <= 1'b1;
              end
            endcase
          end
        end
        S_READ: st_r <= S_EVAL;
        S_EVAL: begin
          if (cmd_r == ffba_pkg::CMD_ALLOC && rd_free_r) begin
            st_r <= S_PAD;
          end else if (we) begin
            bytes_r <= (bytes_r >= rd_size_r) ? bytes_r - rd_size_r : 32'd0;
            cells_r <= (cells_r != '0) ? cells_r - CW'(1) : '0;
            st_r <= S_OUT;
            ov_r <= 1'b1;
          end else if (idx_r + CW'(1) >= used_r) begin
            ost_r <= (cmd_r == ffba_pkg::CMD_ALLOC) ?
                     ffba_pkg::ST_NOFIT : ffba_pkg::ST_NOTALLOC;
            st_r <= S_OUT;
            ov_r <= 1'b1;
          end else begin
            idx_r <= idx_r + CW'(1);
            st_r <= S_READ;
          end
        end
        S_PAD: begin
          if (prsp.done) begin
            if (fits && !exact && used_r >= CW'(ffba_pkg::MaxBlocks)) begin
              ost_r <= ffba_pkg::ST_FULL;
              st_r <= S_OUT;
              ov_r <= 1'b1;
            end else if (fits) begin
              if (!exact) used_r <= used_r + CW'(1);
              ores_r <= woff;
              cells_r <= cells_r + CW'(1);
              bytes_r <= bytes_r + req_r;
              st_r <= S_OUT;
              ov_r <= 1'b1;
            end else if (idx_r + CW'(1) >= used_r) begin
              ost_r <= ffba_pkg::ST_NOFIT;
              st_r <= S_OUT;
              ov_r <= 1'b1;
            end else begin
              idx_r <= idx_r + CW'(1);
              st_r <= S_READ;
            end
          end
        end
        S_INIT: begin
          if (prsp.done) begin
            used_r <= CW'(1);
            cells_r <= '0;
            bytes_r <= '0;
            st_r <= S_OUT;
            ov_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            ov_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> tb/tb_first_fit_block_allocator_core.sv
// Testbench for first_fit_block_allocator_core: directed and random commands checked
// against an in-bench first-fit table predictor. Depends on ffba_pkg and the core.
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_block_allocator_core;
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] req;
    logic [31:0] off;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [10:0] cells;
    logic [31:0] bytes;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic [31:0] in_request_size = '0;
  logic [31:0] in_block_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [31:0] out_result_offset;
  logic [10:0] out_live_cells;
  logic [31:0] out_allocated_bytes;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  first_fit_block_allocator_core DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [8:0]  m_align;
  logic [15:0] m_hstart;
  logic [31:0] m_hend;
  logic [31:0] m_eoff [ffba_pkg::MaxBlocks];
  logic [31:0] m_esize [ffba_pkg::MaxBlocks];
  logic        m_efree [ffba_pkg::MaxBlocks];
  int          m_used;
  logic [10:0] m_cells;
  logic [31:0] m_bytes;

  word_t   pending_words[$];
  result_t expected_results[$];
  logic [31:0] live_offsets[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_sender = 0;

  function automatic logic [31:0] pad_for(logic [31:0] o);
    logic [31:0] a, r;
    a = (m_align == 9'd0) ? 32'd1 : {23'd0, m_align};
    r = o % a;
    return (r != 32'd0) ? a - r : 32'd0;
  endfunction

  function automatic result_t allocator_step(word_t w);
    result_t r;
    logic [31:0] p, av, sz;
    r = '0;
    r.status = ffba_pkg::ST_OK;
    if (w.cmd == ffba_pkg::CMD_INIT) begin
      sz = (m_hend >= {16'd0, m_hstart}) ? m_hend - {16'd0, m_hstart} : 32'd0;
      p = pad_for({16'd0, m_hstart});
      m_eoff[0] = {16'd0, m_hstart} + p;
      m_esize[0] = (sz >= p) ? sz - p : 32'd0;
      m_efree[0] = 1'b1;
      m_used = 1;
      m_cells = '0;
      m_bytes = '0;
    end else if (w.cmd == ffba_pkg::CMD_ALLOC) begin
      r.status = ffba_pkg::ST_NOFIT;
      for (int i = 0; i < m_used; i++) begin
        if (!m_efree[i]) continue;
        p = pad_for(m_eoff[i]);
        if (m_esize[i] < p) continue;
        av = m_esize[i] - p;
        if (av < w.req) continue;
        if (av != w.req && m_used >= ffba_pkg::MaxBlocks) begin
          r.status = ffba_pkg::ST_FULL;
          break;
        end
        m_eoff[i] += p;
        m_esize[i] = av;
        if (av != w.req) begin
          m_eoff[m_used] = m_eoff[i] + w.req;
          m_esize[m_used] = av - w.req;
          m_efree[m_used] = 1'b1;
          m_used++;
          m_esize[i] = w.req;
        end
        m_efree[i] = 1'b0;
        m_cells = m_cells + 11'd1;
        m_bytes = m_bytes + w.req;
        r.status = ffba_pkg::ST_OK;
        r.offset = m_eoff[i];
        live_offsets.insert(live_offsets.size(), m_eoff[i]);
        break;
      end
    end else if (w.cmd == ffba_pkg::CMD_FREE) begin
      r.status = ffba_pkg::ST_NOTALLOC;
      for (int i = 0; i < m_used; i++) begin
        if (!m_efree[i] && m_eoff[i] == w.off) begin
          m_efree[i] = 1'b1;
          m_bytes = (m_bytes >= m_esize[i]) ? m_bytes - m_esize[i] : 32'd0;
          m_cells = (m_cells != 11'd0) ? m_cells - 11'd1 : 11'd0;
          r.status = ffba_pkg::ST_OK;
          break;
        end
      end
    end
    r.cells = m_cells;
    r.bytes = m_bytes;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(),
                                allocator_step({in_command, in_request_size,
                                                in_block_offset}));
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && !hold_sender &&
            (quiet || $urandom_range(99) >= 12)) begin
          word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_command <= w.cmd;
          in_request_size <= w.req;
          in_block_offset <= w.off;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word, status %0d", out_status);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (e !== {out_status, out_result_offset, out_live_cells, out_allocated_bytes}) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st %0d off %h cells %0d bytes %h, got %0d %h %0d %h",
                     e.status, e.offset, e.cells, e.bytes, out_status,
                     out_result_offset, out_live_cells, out_allocated_bytes);
        end
      end
    end
    if (cycles > 40000000) begin
      $display("** first_fit_block_allocator_core: FAILED **");
      $finish;
    end
  end

  task automatic push_word(logic [1:0] c, logic [31:0] q, logic [31:0] o);
    word_t w;
    w.cmd = c;
    w.req = q;
    w.off = o;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffba_pkg::CFG_ALIGN) m_align = val[8:0];
    else if (idx == ffba_pkg::CFG_START) m_hstart = val[15:0];
    else m_hend = val;
  endtask

  // random phase: mostly allocs of small sizes and frees of earlier allocated offsets
  task automatic random_words(int n);
    logic [31:0] o;
    for (int k = 0; k < n; k++) begin
      int sel;
      sel = $urandom_range(99);
      if (sel < 2) push_word(ffba_pkg::CMD_INIT, $urandom, $urandom);
      else if (sel < 3) push_word(ffba_pkg::CMD_NOP, $urandom, $urandom);
      else if (sel < 50) begin
        if ($urandom_range(19) == 0) push_word(ffba_pkg::CMD_ALLOC, $urandom, $urandom);
        else push_word(ffba_pkg::CMD_ALLOC, $urandom_range(300), $urandom);
      end else begin
        // free targets are guessed from earlier successful offsets
        if (live_offsets.size() > 0 && $urandom_range(9) != 0)
          o = live_offsets[$urandom_range(live_offsets.size() - 1)];
        else o = $urandom;
        push_word(ffba_pkg::CMD_FREE, $urandom, o);
      end
    end
  endtask

  initial begin
    m_align = 9'd4;
    m_hstart = 16'd64;
    m_hend = 32'd1048576;
    m_used = 0;
    m_cells = '0;
    m_bytes = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    push_word(ffba_pkg::CMD_ALLOC, 32'd16, 32'd0);
    push_word(ffba_pkg::CMD_FREE, 32'd0, 32'd64);
    push_word(ffba_pkg::CMD_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(ffba_pkg::CMD_ALLOC, 32'd0, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'd13, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'd7, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
    push_word(ffba_pkg::CMD_FREE, 32'd0, 32'd64);
    push_word(ffba_pkg::CMD_FREE, 32'd0, 32'd64);
    push_word(ffba_pkg::CMD_FREE, 32'd0, 32'hFFFF_FFFF);
    push_word(ffba_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(ffba_pkg::CMD_ALLOC, 32'd3, 32'd0);
    drain();
    write_reg(ffba_pkg::CFG_ALIGN, 32'd0);
    write_reg(ffba_pkg::CFG_START, 32'd65535);
    write_reg(ffba_pkg::CFG_END, 32'd100);
    push_word(ffba_pkg::CMD_INIT, 32'd0, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'd0, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'd1, 32'd0);
    drain();
    write_reg(ffba_pkg::CFG_ALIGN, 32'd256);
    write_reg(ffba_pkg::CFG_START, 32'd1);
    write_reg(ffba_pkg::CFG_END, 32'hFFFF_FFFF);
    push_word(ffba_pkg::CMD_INIT, 32'd0, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'd1, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'd1, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'hFFFF_F000, 32'd0);
    drain();
    // table fill with exact fits after full
    write_reg(ffba_pkg::CFG_ALIGN, 32'd1);
    write_reg(ffba_pkg::CFG_START, 32'd0);
    write_reg(ffba_pkg::CFG_END, 32'd640);
    push_word(ffba_pkg::CMD_INIT, 32'd0, 32'd0);
    for (int k = 0; k < 66; k++) push_word(ffba_pkg::CMD_ALLOC, 32'd5, 32'd0);
    push_word(ffba_pkg::CMD_FREE, 32'd0, 32'd5);
    push_word(ffba_pkg::CMD_ALLOC, 32'd5, 32'd0);
    push_word(ffba_pkg::CMD_ALLOC, 32'd4, 32'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ffba_pkg::CFG_ALIGN, (ph == 0) ? 32'd1 : $urandom_range(256));
      write_reg(ffba_pkg::CFG_START, $urandom_range(65535));
      write_reg(ffba_pkg::CFG_END,
                (ph == 5) ? $urandom : 32'd65536 + $urandom_range(200000));
      push_word(ffba_pkg::CMD_INIT, 32'd0, 32'd0);
      quiet = (ph == 2);
      random_words(330);
      if (ph == 3) begin
        hold_sender = 1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        hold_sender = 0;
      end
      drain();
      quiet = 0;
      live_offsets.delete();
    end

    if (errors == 0) $display("** first_fit_block_allocator_core: PASSED **");
    else $display("** first_fit_block_allocator_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
